// ===== src/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// Types and constants shared by the timer scheduler and its checker.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int RESULT_LIMIT = 16;
   localparam int COUNT_W      = $clog2(RESULT_LIMIT + 1);

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_ONESHOT = 2'd1,
      OP_RECUR   = 2'd2,
      OP_DELETE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_FIRED   = 2'd0,
      KIND_ACCEPT  = 2'd1,
      KIND_REJECT  = 2'd2,
      KIND_DELETED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic [31:0] ident;
      logic [31:0] deadline;
      logic [30:0] interval;
      logic        repeats;
   } slot_type;

endpackage

// ===== src/mts_if.sv =====
// ----------------------------------------------------------------------------
// mts channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mts_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         operation;
   logic [31:0]        timer_id;
   logic signed [31:0] delay_ticks;

   modport source (output valid, output operation, output timer_id, output delay_ticks,
                   input ready);
   modport sink   (input valid, input operation, input timer_id, input delay_ticks,
                   output ready);
endinterface

interface mts_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] fired_or_echo_id;
   logic        last;

   modport source (output valid, output kind, output fired_or_echo_id, output last,
                   input ready);
   modport sink   (input valid, input kind, input fired_or_echo_id, input last,
                   output ready);
endinterface

// ===== src/multi_timer_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// multi_timer_scheduler_core
// Software-style timer queue: slot table in one synchronous memory, swept
// one slot per cycle to fire due timers, cancel ids and find free slots.
//
//   channel   direction  handshake          payload
//   req_chan  in         valid/ready        operation, timer_id, delay_ticks
//   rsp_chan  out        valid/ready        kind, fired_or_echo_id, last
//   csr_*     in         write enable only  enabled
//
// a pass sweeps every slot of the memory; each request is taken in the idle state before its first pass
// create and delete: one pass, then the response is handed over in the flush state
// tick: a pass per fired timer and a closing pass, at most 16 fires; the closing pass is
// skipped after a sixteenth fire that reloads, and a tick while disabled makes no pass
// one response waits in the output register, so the next request is taken while it stalls
// synchronous reset clears time, valid bits and control, holds ready low; enabled resets to 1
// ----------------------------------------------------------------------------
module multi_timer_scheduler_core #(
   parameter int MAX_TIMERS = 16
) (
   input  logic       clock,
   input  logic       reset,
   mts_req_if.sink    req_chan,
   mts_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic       csr_wdata
);

   localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int PTR_W = $clog2(MAX_TIMERS + 1);
   localparam logic [PTR_W-1:0] PTR_END = PTR_W'(MAX_TIMERS);
   localparam logic [mts_pkg::COUNT_W-1:0] COUNT_END =
      mts_pkg::COUNT_W'(mts_pkg::RESULT_LIMIT);

   mts_pkg::state_type state_ff, state_in;
   logic               enabled_ff;
   logic [31:0]        time_ff, time_in;
   mts_pkg::op_type    op_ff, op_in;
   logic [31:0]        req_id_ff, req_id_in;
   logic [30:0]        delay_ff, delay_in;

   logic [MAX_TIMERS-1:0] valid_ff, valid_in;
   logic [MAX_TIMERS-1:0] done_ff, done_in;

   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic               stg_vld_ff, stg_vld_in;
   logic [IDX_W-1:0]   stg_idx_ff, stg_idx_in;
   mts_pkg::slot_type  rd_word_ff;

   logic               sel_en_ff, sel_en_in;
   logic               cancel_act_ff, cancel_act_in;
   logic [31:0]        cancel_id_ff, cancel_id_in;
   logic               best_found_ff, best_found_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   mts_pkg::slot_type  best_word_ff, best_word_in;
   logic [31:0]        best_late_ff, best_late_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic [mts_pkg::COUNT_W-1:0] count_ff, count_in;

   logic               pend_ff, pend_in;
   mts_pkg::kind_type  pend_kind_ff, pend_kind_in;
   logic [31:0]        pend_id_ff, pend_id_in;

   logic               rsp_valid_ff, rsp_valid_in;
   mts_pkg::kind_type  rsp_kind_ff, rsp_kind_in;
   logic [31:0]        rsp_id_ff, rsp_id_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   mts_pkg::slot_type  mem_wd;
   mts_pkg::slot_type  slot_mem [MAX_TIMERS];

   logic               req_ready;
   logic               out_free;
   logic [31:0]        late;
   logic               hit_cancel;
   logic               stg_valid_bit;

   assign req_chan.ready            = req_ready;
   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.kind             = rsp_kind_ff;
   assign rsp_chan.fired_or_echo_id = rsp_id_ff;
   assign rsp_chan.last             = rsp_last_ff;

   // slot table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_wa] <= mem_wd;
      end
      rd_word_ff <= slot_mem[ptr_ff[IDX_W-1:0]];
   end

   always_comb begin
      state_in      = state_ff;
      time_in       = time_ff;
      op_in         = op_ff;
      req_id_in     = req_id_ff;
      delay_in      = delay_ff;
      valid_in      = valid_ff;
      done_in       = done_ff;
      ptr_in        = ptr_ff;
      stg_vld_in    = 1'b0;
      stg_idx_in    = ptr_ff[IDX_W-1:0];
      sel_en_in     = sel_en_ff;
      cancel_act_in = cancel_act_ff;
      cancel_id_in  = cancel_id_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_word_in  = best_word_ff;
      best_late_in  = best_late_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      count_in      = count_ff;
      pend_in       = pend_ff;
      pend_kind_in  = pend_kind_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_wa        = best_idx_ff;
      mem_wd        = best_word_ff;
      req_ready     = (state_ff == mts_pkg::ST_IDLE) && !reset;

      out_free = !rsp_valid_ff || rsp_chan.ready;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      // slot evaluation, one slot per cycle
      stg_valid_bit = valid_ff[stg_idx_ff];
      late          = time_ff - rd_word_ff.deadline;
      hit_cancel    = cancel_act_ff && stg_valid_bit && (rd_word_ff.ident == cancel_id_ff);
      if (stg_vld_ff) begin
         if (hit_cancel) begin
            valid_in[stg_idx_ff] = 1'b0;
         end
         if (sel_en_ff && stg_valid_bit && !hit_cancel && !done_ff[stg_idx_ff] && !late[31]
             && (!best_found_ff || (late > best_late_ff))) begin
            best_found_in = 1'b1;
            best_idx_in   = stg_idx_ff;
            best_word_in  = rd_word_ff;
            best_late_in  = late;
         end
         if (!stg_valid_bit && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = stg_idx_ff;
         end
      end

      case (state_ff)
         mts_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               op_in         = mts_pkg::op_type'(req_chan.operation);
               req_id_in     = req_chan.timer_id;
               delay_in      = req_chan.delay_ticks[31] ? 31'd0 : req_chan.delay_ticks[30:0];
               ptr_in        = '0;
               best_found_in = 1'b0;
               free_found_in = 1'b0;
               pend_in       = 1'b0;
               count_in      = '0;
               done_in       = '0;
               sel_en_in     = 1'b0;
               cancel_act_in = 1'b0;
               cancel_id_in  = req_chan.timer_id;
               case (mts_pkg::op_type'(req_chan.operation))
                  mts_pkg::OP_TICK: begin
                     time_in = time_ff + 32'd1;
                     if (enabled_ff) begin
                        sel_en_in = 1'b1;
                        state_in  = mts_pkg::ST_SCAN;
                     end
                  end
                  mts_pkg::OP_DELETE: begin
                     cancel_act_in = 1'b1;
                     state_in      = mts_pkg::ST_SCAN;
                  end
                  default: begin
                     state_in = mts_pkg::ST_SCAN;
                  end
               endcase
            end
         end

         mts_pkg::ST_SCAN: begin
            if (ptr_ff != PTR_END) begin
               ptr_in     = ptr_ff + PTR_W'(1);
               stg_vld_in = 1'b1;
            end else if (!stg_vld_ff) begin
               state_in = mts_pkg::ST_DECIDE;
            end
         end

         mts_pkg::ST_DECIDE: begin
            case (op_ff)
               mts_pkg::OP_TICK: begin
                  if (!best_found_ff) begin
                     cancel_act_in = 1'b0;
                     state_in      = pend_ff ? mts_pkg::ST_FLUSH : mts_pkg::ST_IDLE;
                  end else if (!pend_ff || out_free) begin
                     if (pend_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = mts_pkg::KIND_FIRED;
                        rsp_id_in    = pend_id_ff;
                        rsp_last_in  = 1'b0;
                     end
                     pend_in              = 1'b1;
                     pend_kind_in         = mts_pkg::KIND_FIRED;
                     pend_id_in           = best_word_ff.ident;
                     done_in[best_idx_ff] = 1'b1;
                     count_in             = count_ff + mts_pkg::COUNT_W'(1);
                     ptr_in               = '0;
                     best_found_in        = 1'b0;
                     if (best_word_ff.repeats) begin
                        mem_we          = 1'b1;
                        mem_wd.deadline = time_ff + {1'b0, best_word_ff.interval};
                        cancel_act_in   = 1'b0;
                     end else begin
                        valid_in[best_idx_ff] = 1'b0;
                        cancel_act_in         = 1'b1;
                        cancel_id_in          = best_word_ff.ident;
                     end
                     state_in = mts_pkg::ST_SCAN;
                     if (count_ff + mts_pkg::COUNT_W'(1) == COUNT_END) begin
                        sel_en_in = 1'b0;
                        if (best_word_ff.repeats) begin
                           state_in = mts_pkg::ST_FLUSH;
                        end
                     end
                  end
               end
               mts_pkg::OP_DELETE: begin
                  cancel_act_in = 1'b0;
                  pend_in       = 1'b1;
                  pend_kind_in  = mts_pkg::KIND_DELETED;
                  pend_id_in    = req_id_ff;
                  state_in      = mts_pkg::ST_FLUSH;
               end
               default: begin
                  pend_in    = 1'b1;
                  pend_id_in = req_id_ff;
                  if (enabled_ff && free_found_ff) begin
                     pend_kind_in          = mts_pkg::KIND_ACCEPT;
                     mem_we                = 1'b1;
                     mem_wa                = free_idx_ff;
                     mem_wd.ident          = req_id_ff;
                     mem_wd.deadline       = time_ff + {1'b0, delay_ff};
                     mem_wd.interval       = delay_ff;
                     mem_wd.repeats        = (op_ff == mts_pkg::OP_RECUR);
                     valid_in[free_idx_ff] = 1'b1;
                  end else begin
                     pend_kind_in = mts_pkg::KIND_REJECT;
                  end
                  state_in = mts_pkg::ST_FLUSH;
               end
            endcase
         end

         mts_pkg::ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = pend_kind_ff;
               rsp_id_in    = pend_id_ff;
               rsp_last_in  = 1'b1;
               pend_in      = 1'b0;
               state_in     = mts_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = mts_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mts_pkg::ST_IDLE;
         enabled_ff    <= 1'b1;
         time_ff       <= '0;
         valid_ff      <= '0;
         done_ff       <= '0;
         ptr_ff        <= '0;
         stg_vld_ff    <= 1'b0;
         sel_en_ff     <= 1'b0;
         cancel_act_ff <= 1'b0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_we) begin
            enabled_ff <= csr_wdata;
         end
         time_ff       <= time_in;
         valid_ff      <= valid_in;
         done_ff       <= done_in;
         ptr_ff        <= ptr_in;
         stg_vld_ff    <= stg_vld_in;
         sel_en_ff     <= sel_en_in;
         cancel_act_ff <= cancel_act_in;
         best_found_ff <= best_found_in;
         free_found_ff <= free_found_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      req_id_ff    <= req_id_in;
      delay_ff     <= delay_in;
      stg_idx_ff   <= stg_idx_in;
      cancel_id_ff <= cancel_id_in;
      best_idx_ff  <= best_idx_in;
      best_word_ff <= best_word_in;
      best_late_ff <= best_late_in;
      free_idx_ff  <= free_idx_in;
      pend_kind_ff <= pend_kind_in;
      pend_id_ff   <= pend_id_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_last_ff  <= rsp_last_in;
   end

endmodule

// ===== src/mts_checker.sv =====
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks on the timer scheduler, bound to multi_timer_scheduler_core.
// ----------------------------------------------------------------------------
module mts_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic [31:0] rsp_id,
   input logic        rsp_last
);

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kind) && $stable(rsp_id) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_single_rsp_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != mts_pkg::KIND_FIRED) |-> rsp_last)
      else $error("create or delete response without last");

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_operation != mts_pkg::OP_TICK) |=> !req_ready)
      else $error("new request taken before slot sweep");

endmodule

bind multi_timer_scheduler_core mts_checker u_mts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_operation (req_chan.operation),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_kind      (rsp_chan.kind),
   .rsp_id        (rsp_chan.fired_or_echo_id),
   .rsp_last      (rsp_chan.last)
);
